[rtl/mld_pkg.sv]
// ----------------------------------------------------------------------------
// mld_pkg
// Shared types and constants of the magic/length deframer.
// ----------------------------------------------------------------------------
package mld_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int QUEUE_DEPTH  = 4;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_MAGIC_WORD  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'b1;

	localparam logic [1:0] ST_PAYLOAD   = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data_byte;
		logic       last_of_frame;
	} result_t;

endpackage

[rtl/mld_front.sv]
// ----------------------------------------------------------------------------
// mld_front
// Header parser: collects magic and length, checks them, tags payload bytes.
// ----------------------------------------------------------------------------
module mld_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mld_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  logic [15:0]                    cfg_data,
	input  logic                           in_valid,
	input  logic [7:0]                     in_byte,
	output logic                           push,
	output mld_pkg::result_t               push_item
);

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_HDR2    = 3'd2;
	localparam logic [2:0] PH_HDR3    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'(mld_pkg::HEADER_BYTES);

	logic [15:0] magic_word_q;
	logic [15:0] max_payload_q;
	logic [2:0]  phase_q;
	logic [15:0] magic_hold_q;
	logic [7:0]  length_high_q;
	logic [15:0] bytes_left_q;

	logic [2:0]  phase_d;
	logic [15:0] magic_hold_d;
	logic [7:0]  length_high_d;
	logic [15:0] bytes_left_d;
	logic [15:0] len;
	logic [15:0] left_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q  <= '0;
			max_payload_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_addr)
				mld_pkg::REG_MAGIC_WORD:  magic_word_q  <= cfg_data;
				mld_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign len      = {length_high_q, in_byte};
	assign left_dec = bytes_left_q - 16'd1;

	always_comb begin
		phase_d       = phase_q;
		magic_hold_d  = magic_hold_q;
		length_high_d = length_high_q;
		bytes_left_d  = bytes_left_q;
		push          = 1'b0;
		push_item     = '{status: mld_pkg::ST_PAYLOAD, data_byte: 8'h00, last_of_frame: 1'b0};
		if (in_valid) begin
			case (phase_q)
				PH_PAYLOAD: begin
					bytes_left_d = left_dec;
					if (left_dec == 16'd0)
						phase_d = PH_HDR0;
					push      = 1'b1;
					push_item = '{status: mld_pkg::ST_PAYLOAD, data_byte: in_byte,
						last_of_frame: (left_dec == 16'd0)};
				end
				PH_HDR1: begin
					magic_hold_d = {magic_hold_q[15:8], in_byte};
					phase_d      = PH_HDR2;
				end
				PH_HDR2: begin
					length_high_d = in_byte;
					phase_d       = PH_HDR3;
				end
				PH_HDR3: begin
					phase_d = PH_HDR0;
					if (magic_hold_q != magic_word_q) begin
						push           = 1'b1;
						push_item.status = mld_pkg::ST_BAD_MAGIC;
					end else if (len > max_payload_q) begin
						push           = 1'b1;
						push_item.status = mld_pkg::ST_TOO_LONG;
					end else if (len == 16'd0) begin
						push                    = 1'b1;
						push_item.status        = mld_pkg::ST_EMPTY;
						push_item.last_of_frame = 1'b1;
					end else begin
						bytes_left_d = len;
						phase_d      = PH_PAYLOAD;
					end
				end
				default: begin
					magic_hold_d = {in_byte, 8'h00};
					phase_d      = PH_HDR1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HDR0;
			magic_hold_q  <= '0;
			length_high_q <= '0;
			bytes_left_q  <= '0;
		end else begin
			phase_q       <= phase_d;
			magic_hold_q  <= magic_hold_d;
			length_high_q <= length_high_d;
			bytes_left_q  <= bytes_left_d;
		end
	end

endmodule

[rtl/mld_queue.sv]
// ----------------------------------------------------------------------------
// mld_queue
// Short result queue between header parser and output stage.
// ----------------------------------------------------------------------------
module mld_queue #(
	parameter int DEPTH = mld_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mld_pkg::result_t push_item,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output mld_pkg::result_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mld_pkg::result_t   mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[rtl/mld_back.sv]
// ----------------------------------------------------------------------------
// mld_back
// Output register driving the result stream.
// ----------------------------------------------------------------------------
module mld_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mld_pkg::result_t q_head,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	logic             valid_q;
	mld_pkg::result_t item_q;

	assign q_pop    = q_valid && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = item_q.data_byte;
	assign m_tuser  = item_q.status;
	assign m_tlast  = item_q.last_of_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || m_tready)
			valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			item_q <= q_head;
	end

endmodule

[rtl/magic_length_deframer.sv]
// ----------------------------------------------------------------------------
// magic_length_deframer
// Splits a byte stream into frames with a magic/length header.
//
//   channel   dir  handshake           payload
//   s_        in   s_tvalid/s_tready   s_tdata[7:0] rx_byte
//   m_        out  m_tvalid/m_tready   m_tdata data_byte, m_tuser status,
//                                      m_tlast last_of_frame
//   cfg_      in   cfg_we              cfg_addr index, cfg_data value
//
// One byte accepted per cycle while s_tready is high; results pass queue and output reg.
// s_tready drops only when the result queue is full.
// A stalled output holds its word; the queue absorbs up to QUEUE_DEPTH results.
// Reset clears header state and restores magic 0, maximum length 65535.
// ----------------------------------------------------------------------------
module magic_length_deframer #(
	parameter int QUEUE_DEPTH = mld_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] data_byte
	output logic [1:0]                    m_tuser,   // [1:0] status
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [mld_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [15:0]                   cfg_data
);

	logic             push;
	mld_pkg::result_t push_item;
	logic             q_not_full;
	logic             q_not_empty;
	logic             q_pop;
	mld_pkg::result_t q_head;

	assign s_tready = q_not_full;

	mld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid && q_not_full),
		.in_byte   (s_tdata),
		.push      (push),
		.push_item (push_item)
	);

	mld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	mld_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_not_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
